// ===== rtl/pid_controller_clamped_macros.svh =====
// Assertion macros shared by the controller RTL.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PIDC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define PIDC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define PIDC_ASSERT_IMP(name, ante, cons)

`define PIDC_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ===== rtl/pidc_pkg.sv =====
`timescale 1ns / 1ps

package pidc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_HIGH    = 3'd6;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // Divider: 32 quotient bits, one per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_IDLE = '0;

  // Operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GD_DIFF,
    MUL_GI_ERR,
    MUL_GP_ERR,
    MUL_LO_DT,
    MUL_HI_DT
  } mul_sel_t;

  // Datapath action of one step
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_DIV_START,
    ALU_GIE,
    ALU_PTERM,
    ALU_ACC_LO,
    ALU_ACC_HI,
    ALU_INC,
    ALU_INTEG_ADD,
    ALU_INTEG_CLAMP,
    ALU_PSUM,
    ALU_DTERM,
    ALU_DRIVE,
    ALU_EMIT
  } alu_op_t;

  // Hold condition of one step
  typedef enum logic [1:0] {
    C_NONE,
    C_WAIT_IN,
    C_WAIT_DIV,
    C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    mul_sel_t mul;
    alu_op_t  alu;
    cond_t    cond;
    logic     jump;
    step_t    target;
  } uword_t;

  function automatic uword_t uw(input mul_sel_t m, input alu_op_t a, input cond_t c,
                                input logic j);
    uword_t w;
    w = '{mul: m, alu: a, cond: c, jump: j, target: STEP_IDLE};
    return w;
  endfunction

  // Control store
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = uw(MUL_NONE, ALU_NOP, C_NONE, 1'b1);
    unique case (s)
      4'd0:  w = uw(MUL_NONE,    ALU_LOAD,        C_WAIT_IN,  1'b0);
      4'd1:  w = uw(MUL_GD_DIFF, ALU_NOP,         C_NONE,     1'b0);
      4'd2:  w = uw(MUL_GI_ERR,  ALU_DIV_START,   C_NONE,     1'b0);
      4'd3:  w = uw(MUL_GP_ERR,  ALU_GIE,         C_NONE,     1'b0);
      4'd4:  w = uw(MUL_LO_DT,   ALU_PTERM,       C_NONE,     1'b0);
      4'd5:  w = uw(MUL_HI_DT,   ALU_ACC_LO,      C_NONE,     1'b0);
      4'd6:  w = uw(MUL_NONE,    ALU_ACC_HI,      C_NONE,     1'b0);
      4'd7:  w = uw(MUL_NONE,    ALU_INC,         C_NONE,     1'b0);
      4'd8:  w = uw(MUL_NONE,    ALU_INTEG_ADD,   C_NONE,     1'b0);
      4'd9:  w = uw(MUL_NONE,    ALU_INTEG_CLAMP, C_NONE,     1'b0);
      4'd10: w = uw(MUL_NONE,    ALU_PSUM,        C_NONE,     1'b0);
      4'd11: w = uw(MUL_NONE,    ALU_NOP,         C_WAIT_DIV, 1'b0);
      4'd12: w = uw(MUL_NONE,    ALU_DTERM,       C_NONE,     1'b0);
      4'd13: w = uw(MUL_NONE,    ALU_DRIVE,       C_NONE,     1'b0);
      4'd14: w = uw(MUL_NONE,    ALU_EMIT,        C_WAIT_OUT, 1'b1);
      default: w = uw(MUL_NONE,  ALU_NOP,         C_NONE,     1'b1);
    endcase
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Upper limit tested first when the limits cross: a value above it takes hi, any other takes lo
  function automatic logic signed [31:0] clamp32(input logic signed [31:0] x,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

endpackage

// ===== rtl/pid_controller_clamped.sv =====
`timescale 1ns / 1ps
// Each sample runs the whole control store before the next is taken; the divider is
//   skipped when the derivative overflows or the interval is zero. Emitting waits
//   while out_tready holds back the previous result. The bit-serial divider of the
//   derivative term bounds the rate; the multiplier steps run alongside it.
`include "pid_controller_clamped_macros.svh"

module pid_controller_clamped
  import pidc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data,
  // Sample input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // target[15:0], measured[31:16], interval[47:32]
  // Drive output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // drive[31:0]
);

  // Reset (rst_n low, synchronous): all gains and limits, the stored integral
  // and the previous error clear to zero; the sequencer returns to idle.

  // Configuration registers
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [31:0] integral_low_r, integral_high_r, drive_low_r, drive_high_r;

  // Sequencer
  step_t  step_r, step_nxt;
  uword_t cw;
  logic   step_go;

  // Loop state
  logic signed [31:0] integ_r;
  logic signed [16:0] prev_err_r;

  // Per-item working registers
  logic signed [16:0] err_r;
  logic signed [17:0] diff_r;
  logic [15:0]        dt_r;
  logic signed [50:0] prod_r;
  logic signed [48:0] gie_r;
  logic signed [65:0] acc_r;
  logic signed [31:0] p_r, inc_r, d_r, drv_r;
  logic signed [33:0] psum_r;

  // Divider
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [15:0]          div_rem_r;
  logic [15:0]          div_sh_r;
  logic [31:0]          div_quo_r;
  logic                 div_neg_r, div_ovf_r;

  logic                 out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // Input fields
  logic signed [15:0] in_target, in_measured;
  logic [15:0]        in_interval;
  logic signed [16:0] err_in;
  logic signed [17:0] diff_in;

  assign in_target   = in_tdata[15:0];
  assign in_measured = in_tdata[31:16];
  assign in_interval = in_tdata[47:32];
  assign err_in      = 17'(in_target) - 17'(in_measured);
  assign diff_in     = 18'(err_in) - 18'(prev_err_r);

  // Fetch the control word and decide whether the step completes this cycle
  assign cw = ucode(step_r);

  always_comb begin
    case (cw.cond)
      C_WAIT_IN:  step_go = in_tvalid;
      C_WAIT_DIV: step_go = (div_cnt_r == '0);
      C_WAIT_OUT: step_go = !out_tvalid_r || out_tready;
      default:    step_go = 1'b1;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (step_go) begin
      step_nxt = cw.jump ? cw.target : step_r + step_t'(1);
    end
  end

  assign in_tready  = (cw.cond == C_WAIT_IN);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Shared multiplier: 33 x 18 signed, registered into prod_r
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;

  always_comb begin
    case (cw.mul)
      MUL_GD_DIFF: begin
        mul_a = 33'(gain_d_r);
        mul_b = diff_r;
      end
      MUL_GI_ERR: begin
        mul_a = 33'(gain_i_r);
        mul_b = 18'(err_r);
      end
      MUL_GP_ERR: begin
        mul_a = 33'(gain_p_r);
        mul_b = 18'(err_r);
      end
      MUL_LO_DT: begin
        // low word of ki*err taken as unsigned
        mul_a = {1'b0, gie_r[31:0]};
        mul_b = {2'b00, dt_r};
      end
      MUL_HI_DT: begin
        mul_a = 33'($signed(gie_r[48:32]));
        mul_b = {2'b00, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Divider set-up: |kd*diff| * 2^16 / dt, quotient capped by the overflow test
  logic signed [50:0] div_src_neg;
  logic [49:0]        div_mag;
  logic [33:0]        div_hi;
  logic               div_ovf_in;
  logic [16:0]        div_trial;
  logic               div_qbit;

  assign div_src_neg = -prod_r;
  assign div_mag     = prod_r[50] ? div_src_neg[49:0] : prod_r[49:0];
  assign div_hi      = div_mag[49:16];
  assign div_ovf_in  = (div_hi >= {18'b0, dt_r});
  assign div_trial   = {div_rem_r, div_sh_r[15]};
  assign div_qbit    = (div_trial >= {1'b0, dt_r});

  always_comb begin
    div_cnt_nxt = div_cnt_r;
    if (step_go && cw.alu == ALU_DIV_START) begin
      div_cnt_nxt = div_ovf_in ? '0 : DIV_CNT_W'(DIV_STEPS);
    end else if (div_cnt_r != '0) begin
      div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
    end
  end

  // Derivative term from the finished quotient
  logic signed [32:0] d_signed;
  logic signed [31:0] d_term;

  assign d_signed = div_neg_r ? -$signed({1'b0, div_quo_r}) : $signed({1'b0, div_quo_r});

  always_comb begin
    if (dt_r == '0) begin
      d_term = '0;
    end else if (div_ovf_r) begin
      d_term = div_neg_r ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      d_term = sat32(66'(d_signed));
    end
  end

  // Control state, configuration, loop state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r          <= STEP_IDLE;
      div_cnt_r       <= '0;
      out_tvalid_r    <= 1'b0;
      gain_p_r        <= '0;
      gain_i_r        <= '0;
      gain_d_r        <= '0;
      integral_low_r  <= '0;
      integral_high_r <= '0;
      drive_low_r     <= '0;
      drive_high_r    <= '0;
      integ_r         <= '0;
      prev_err_r      <= '0;
    end else begin
      step_r    <= step_nxt;
      div_cnt_r <= div_cnt_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GAIN_P:        gain_p_r        <= cfg_data;
          REG_GAIN_I:        gain_i_r        <= cfg_data;
          REG_GAIN_D:        gain_d_r        <= cfg_data;
          REG_INTEGRAL_LOW:  integral_low_r  <= cfg_data;
          REG_INTEGRAL_HIGH: integral_high_r <= cfg_data;
          REG_DRIVE_LOW:     drive_low_r     <= cfg_data;
          REG_DRIVE_HIGH:    drive_high_r    <= cfg_data;
          default: ;  // drop writes past the register list
        endcase
      end

      // Retire the held result once the sink takes it, unless a new one lands
      if (out_tvalid_r && out_tready && !(step_go && cw.alu == ALU_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end

      if (step_go) begin
        case (cw.alu)
          ALU_INTEG_ADD:   integ_r <= sat32(66'(integ_r) + 66'(inc_r));
          ALU_INTEG_CLAMP: integ_r <= clamp32(integ_r, integral_low_r, integral_high_r);
          ALU_EMIT: begin
            out_tvalid_r <= 1'b1;
            prev_err_r   <= err_r;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk) begin
    if (step_go && cw.mul != MUL_NONE) begin
      prod_r <= mul_p;
    end

    // Restoring division, one quotient bit per cycle
    if (div_cnt_r != '0) begin
      div_rem_r <= div_qbit ? 16'(div_trial - {1'b0, dt_r}) : div_trial[15:0];
      div_sh_r  <= {div_sh_r[14:0], 1'b0};
      div_quo_r <= {div_quo_r[30:0], div_qbit};
    end

    if (step_go) begin
      case (cw.alu)
        ALU_LOAD: begin
          err_r  <= err_in;
          diff_r <= diff_in;
          dt_r   <= in_interval;
        end
        ALU_DIV_START: begin
          div_neg_r <= prod_r[50];
          div_ovf_r <= div_ovf_in;
          div_rem_r <= div_hi[15:0];
          div_sh_r  <= div_mag[15:0];
          div_quo_r <= '0;
        end
        ALU_GIE:    gie_r  <= prod_r[48:0];
        ALU_PTERM:  p_r    <= sat32(66'(prod_r));
        ALU_ACC_LO: acc_r  <= 66'(prod_r);
        ALU_ACC_HI: acc_r  <= acc_r + (66'(prod_r) <<< 32);
        // floor shift of ki*err*dt, then saturate
        ALU_INC:    inc_r  <= sat32(acc_r >>> 16);
        ALU_PSUM:   psum_r <= 34'(p_r) + 34'(integ_r);
        ALU_DTERM:  d_r    <= d_term;
        ALU_DRIVE:  drv_r  <= sat32(66'(psum_r) + 66'(d_r));
        ALU_EMIT:   out_tdata_r <= clamp32(drv_r, drive_low_r, drive_high_r);
        default: ;
      endcase
    end
  end

  // Divider is always drained by the time a new sample can be taken
  `PIDC_ASSERT_IMP(a_idle_div_done, in_tready, div_cnt_r == '0)
  // Emitting a result always leaves one presented
  `PIDC_ASSERT_NXT(a_emit_valid, step_go && (cw.alu == ALU_EMIT), out_tvalid)
  // With ordered limits the stored integral lands inside them
  `PIDC_ASSERT_NXT(a_integ_clamped,
    (cw.alu == ALU_INTEG_CLAMP) && (integral_low_r <= integral_high_r),
    (integ_r >= $past(integral_low_r)) && (integ_r <= $past(integral_high_r)))

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb
  import pidc_pkg::*;
();

  // Settings for one group of register writes, in register order
  typedef struct packed {
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] kd;
    logic [31:0] ilo;
    logic [31:0] ihi;
    logic [31:0] dlo;
    logic [31:0] dhi;
  } gains_t;

  // One directed sample; preset 0 keeps the current settings
  typedef struct packed {
    logic [3:0]  preset;
    logic [15:0] tgt;
    logic [15:0] meas;
    logic [15:0] dt;
    bit          pinned;
    logic [31:0] drive;
  } probe_t;

  // Hand-typed drive value that rides along with a sample
  typedef struct packed {
    bit          pinned;
    logic [31:0] drive;
  } pin_t;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 105;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [31:0]           cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // target[15:0], measured[31:16], interval[47:32]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // drive[31:0]

  // Predictor copy of the registers and the loop state
  logic signed [31:0] set_kp, set_ki, set_kd, set_ilo, set_ihi, set_dlo, set_dhi;
  logic signed [31:0] integ_acc;
  logic signed [16:0] last_err;

  logic [31:0] drive_expect_q [$];
  pin_t        pinned_q [$];
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;

  // Receiver stall state
  int unsigned ready_hold = 0;
  int unsigned ready_mode_left = 0;
  bit          ready_free = 1'b0;
  int unsigned ready_roll;

  gains_t presets [1:7] = '{
    // proportional gain at its maximum, drive unclamped
    '{32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF},
    // proportional gain at its minimum
    '{32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF},
    // unit integral gain, integral unclamped
    '{32'h0, 32'h00010000, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
    // integral gain at its maximum, integral clamped to +/-16.0
    '{32'h0, 32'h7FFFFFFF, 32'h0, 32'hFFF00000, 32'h00100000, 32'h80000000, 32'h7FFFFFFF},
    // derivative gain at its maximum
    '{32'h0, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h80000000, 32'h7FFFFFFF},
    // crossed limits on both the integral and the drive
    '{32'h00010000, 32'h00010000, 32'h0, 32'h00100000, 32'hFFF00000, 32'h00010000, 32'hFFFF0000},
    // drive pinned at the most negative value
    '{32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h80000000}
  };

  probe_t probes [22] = '{
    // out of reset every limit is zero, so the drive is zero
    '{4'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 32'h00000000},
    '{4'd0, 16'h8000, 16'h7FFF, 16'h0001, 1'b1, 32'h00000000},
    // largest error of either sign into the extreme proportional gains
    '{4'd1, 16'h7FFF, 16'h8000, 16'h0064, 1'b1, 32'h7FFFFFFF},
    '{4'd0, 16'h8000, 16'h7FFF, 16'h0064, 1'b1, 32'h80000000},
    '{4'd0, 16'h0000, 16'h0000, 16'h0001, 1'b1, 32'h00000000},
    '{4'd2, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 32'h80000000},
    '{4'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 32'h7FFFFFFF},
    // integral build-up, including a zero interval
    '{4'd3, 16'h0100, 16'h0000, 16'h8000, 1'b0, 32'h0},
    '{4'd0, 16'h0100, 16'h0000, 16'h0000, 1'b0, 32'h0},
    '{4'd0, 16'h0000, 16'h0100, 16'h8000, 1'b0, 32'h0},
    // saturated increment lands on the integral clamps
    '{4'd4, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, 32'h00100000},
    '{4'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 32'hFFF00000},
    '{4'd0, 16'hFFFB, 16'h0000, 16'h0003, 1'b0, 32'h0},
    // derivative saturates both ways; zero interval kills it
    '{4'd5, 16'h7FFF, 16'h8000, 16'h0001, 1'b1, 32'h7FFFFFFF},
    '{4'd0, 16'h8000, 16'h7FFF, 16'h0001, 1'b1, 32'h80000000},
    '{4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h00000000},
    '{4'd0, 16'h0003, 16'h0000, 16'hFFFF, 1'b0, 32'h0},
    // crossed limits: upper limit tested first
    '{4'd6, 16'h0010, 16'h0000, 16'h0064, 1'b0, 32'h0},
    '{4'd0, 16'h0000, 16'h0010, 16'h0064, 1'b0, 32'h0},
    '{4'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0, 32'h0},
    '{4'd7, 16'h1234, 16'h0000, 16'h0001, 1'b1, 32'h80000000},
    '{4'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1, 32'h80000000}
  };

  pid_controller_clamped u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Drive predictor
  // ---------------------------------------------------------------------------

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] fit32(input logic signed [95:0] x);
    if (x > 96'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (x < -96'sh80000000) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Upper limit tested first when the limits cross: a value above it takes hi, any other takes lo
  function automatic logic signed [31:0] limit32(input logic signed [31:0] x,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Advance the loop state by one sample and return the drive it produces
  function automatic logic [31:0] next_drive(input logic [15:0] tgt, input logic [15:0] meas,
                                             input logic [15:0] dt);
    logic signed [16:0] err;
    logic signed [95:0] e, de, dt_w, p, inc, d, sum;
    logic [95:0]        mag, quo;
    err  = {tgt[15], tgt} - {meas[15], meas};
    e    = err;
    de   = last_err;
    de   = e - de;
    dt_w = {80'd0, dt};
    // proportional term, exact product then saturate
    p = set_kp;
    p = fit32(p * e);
    // integral increment floors toward minus infinity
    inc = set_ki;
    inc = fit32((inc * e * dt_w) >>> 16);
    sum = integ_acc;
    integ_acc = limit32(fit32(sum + inc), set_ilo, set_ihi);
    // derivative: scale by 2^16, divide by the interval, truncate toward zero
    if (dt == 16'd0) begin
      d = '0;
    end else begin
      d   = set_kd;
      d   = d * de;
      mag = (d < 0) ? -d : d;
      quo = (mag << 16) / dt_w;
      d   = fit32((d < 0) ? -$signed(quo) : $signed(quo));
    end
    sum = integ_acc;
    sum = sum + p + d;
    last_err = err;
    return limit32(fit32(sum), set_dlo, set_dhi);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: shadow config writes, predict on each input transfer, check each
  // output transfer, and watch for a stalled run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pin_t        pin;
    logic [31:0] predicted;
    logic [31:0] want;
    if (!rst_n) begin
      set_kp      = '0;
      set_ki      = '0;
      set_kd      = '0;
      set_ilo     = '0;
      set_ihi     = '0;
      set_dlo     = '0;
      set_dhi     = '0;
      integ_acc   = '0;
      last_err    = '0;
    end else begin
      // Config only moves while the block is idle, so blocking updates are safe
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:        set_kp  = cfg_data;
          REG_GAIN_I:        set_ki  = cfg_data;
          REG_GAIN_D:        set_kd  = cfg_data;
          REG_INTEGRAL_LOW:  set_ilo = cfg_data;
          REG_INTEGRAL_HIGH: set_ihi = cfg_data;
          REG_DRIVE_LOW:     set_dlo = cfg_data;
          REG_DRIVE_HIGH:    set_dhi = cfg_data;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        pin = '0;
        if (pinned_q.size() != 0) pin = pinned_q.pop_front();
        predicted = next_drive(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
        // A hand-typed value overrides the predictor for that sample
        drive_expect_q.push_back(pin.pinned ? pin.drive : predicted);
      end

      if (out_tvalid && out_tready) begin
        if (drive_expect_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("tb: drive %h arrived with no sample pending", out_tdata);
        end else begin
          want = drive_expect_q.pop_front();
          if (out_tdata !== want) begin
            fault_count++;
            if (fault_count <= 10) $display("tb: drive expected %h got %h", want, out_tdata);
          end
        end
      end
    end

    // Watchdog: count cycles with no transfer on any channel
    if (!rst_n || (cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
        (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, mostly short, a few long, with stall-free stretches
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (ready_mode_left == 0) begin
      ready_free      <= ($urandom_range(0, 3) == 0);
      ready_mode_left <= $urandom_range(100, 600);
    end else begin
      ready_mode_left <= ready_mode_left - 1;
    end

    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (ready_free) begin
      out_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 70) begin
        out_tready <= 1'b1;
      end else if (ready_roll < 95) begin
        ready_hold <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        ready_hold <= $urandom_range(10, 60);
        out_tready <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Gap length before the next sample: mostly none, a few long
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_gain(input bit extreme);
    int unsigned r;
    logic [18:0] s;
    r = $urandom_range(0, 99);
    s = 19'($urandom);
    if (extreme) return (r < 50) ? 32'h7FFFFFFF : 32'h80000000;
    if (r < 10) return '0;
    if (r < 35) return $urandom;
    // modest gains keep the terms out of saturation
    return {{13{s[18]}}, s};
  endfunction

  // Returns {hi, lo}
  function automatic logic [63:0] pick_limits(input bit extreme);
    int unsigned r;
    logic signed [31:0] a, b, m;
    r = $urandom_range(0, 99);
    a = $urandom;
    b = $urandom;
    m = $urandom_range(1, 32'h01000000);
    if (extreme) begin
      if (r < 70) return {32'h7FFFFFFF, 32'h80000000};
      return (r < 85) ? {32'h7FFFFFFF, 32'h7FFFFFFF} : {32'h80000000, 32'h80000000};
    end
    if (r < 30) return {32'h7FFFFFFF, 32'h80000000};
    if (r < 60) return (a > b) ? {a, b} : {b, a};
    if (r < 85) return {m, -m};
    // unordered: the pair may cross
    return {a, b};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input gains_t g);
    write_reg(REG_GAIN_P, g.kp);
    write_reg(REG_GAIN_I, g.ki);
    write_reg(REG_GAIN_D, g.kd);
    write_reg(REG_INTEGRAL_LOW, g.ilo);
    write_reg(REG_INTEGRAL_HIGH, g.ihi);
    write_reg(REG_DRIVE_LOW, g.dlo);
    write_reg(REG_DRIVE_HIGH, g.dhi);
  endtask

  // Hold the sender until every pending drive has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (drive_expect_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Present one sample, hold it until the transfer, then idle for the gap
  task automatic send_sample(input logic [15:0] tgt, input logic [15:0] meas,
                             input logic [15:0] dt, input bit pinned,
                             input logic [31:0] drive, input int unsigned gap);
    pinned_q.push_back('{pinned, drive});
    in_tdata  <= {dt, meas, tgt};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    gains_t      g;
    logic [63:0] lims;
    logic [15:0] tgt, meas, dt;
    int unsigned r;
    bit          steady;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples; a preset drains the block and rewrites every register
    for (int i = 0; i < $size(probes); i++) begin
      if (probes[i].preset != 4'd0) begin
        drain();
        load_settings(presets[probes[i].preset]);
      end
      send_sample(probes[i].tgt, probes[i].meas, probes[i].dt, probes[i].pinned,
                  probes[i].drive, pick_gap(1'b0));
    end

    // Random phases, each under fresh settings; the first uses only extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      g.kp  = pick_gain(ph == 0);
      g.ki  = pick_gain(ph == 0);
      g.kd  = pick_gain(ph == 0);
      lims  = pick_limits(ph == 0);
      g.ihi = lims[63:32];
      g.ilo = lims[31:0];
      lims  = pick_limits(ph == 0);
      g.dhi = lims[63:32];
      g.dlo = lims[31:0];
      load_settings(g);
      steady = (ph % 3 == 1);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mix full-range errors with small ones so the integral and the
        // derivative work away from saturation
        r   = $urandom_range(0, 99);
        tgt = 16'($urandom);
        if (r < 45) meas = 16'($urandom);
        else        meas = tgt + 16'($urandom_range(0, 64)) - 16'd32;
        r = $urandom_range(0, 99);
        if (r < 60)      dt = 16'($urandom_range(1, 65535));
        else if (r < 85) dt = 16'($urandom_range(1, 256));
        else if (r < 94) dt = 16'hFFFF;
        else if (r < 97) dt = 16'h0000;
        else             dt = 16'h0001;
        // now and then let everything drain before the next sample
        if ($urandom_range(0, 99) == 0) drain();
        send_sample(tgt, meas, dt, 1'b0, '0, pick_gap(steady));
      end
    end

    // Wait out the pending drives, then keep watching for stray ones
    in_tvalid <= 1'b0;
    do @(posedge clk); while (drive_expect_q.size() != 0);
    repeat (60) @(posedge clk);

    if (fault_count == 0 && drive_expect_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
